// ===== src/ptls_pkg.sv =====
// ----------------------------------------------------------------------------
// ptls_pkg - shared types and constants for per-topic loss statistics
// Holds field widths, command codes, the table entry layout, the table request
// bundle, the arithmetic unit operations and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ptls_pkg;

  localparam int CmdW   = 2;
  localparam int TopicW = 6;
  localparam int SeqW   = 31;
  localparam int CntW   = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_PUB  = 2'd0,
    CMD_RCV  = 2'd1,
    CMD_PUSH = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  // One statistics row per topic
  typedef struct packed {
    logic [CntW-1:0] pub;
    logic [CntW-1:0] rcv;
    logic [CntW-1:0] drp;
    logic [SeqW-1:0] lseq;
  } entry_t;

  // Request from the sequencer to the statistics table
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [TopicW-1:0] addr;
  } tbl_req_t;

  typedef enum logic {
    ALU_ADD_SAT = 1'b0,  // a + b, clamped at all ones
    ALU_GAP     = 1'b1   // a - b - 1, flag when a <= b
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_PUB,
    S_GAP,
    S_RCV,
    S_DROP,
    S_WRITE,
    S_PUSH_RD,
    S_PUSH_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== src/ptls_alu.sv =====
// ----------------------------------------------------------------------------
// ptls_alu - shared arithmetic unit
// One 33-bit adder used either as a saturating add or as a gap subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module ptls_alu (
  input  wire ptls_pkg::alu_op_t             op,
  input  wire logic [ptls_pkg::CntW-1:0]     a,
  input  wire logic [ptls_pkg::CntW-1:0]     b,
  output logic      [ptls_pkg::CntW-1:0]     res,
  output logic                               no_rise
);

  logic [ptls_pkg::CntW:0] sum;

  always_comb begin
    case (op)
      ptls_pkg::ALU_ADD_SAT: begin
        sum     = {1'b0, a} + {1'b0, b};
        res     = sum[ptls_pkg::CntW] ? '1 : sum[ptls_pkg::CntW-1:0];
        no_rise = 1'b0;
      end
      ptls_pkg::ALU_GAP: begin
        // negative result means a did not rise above b
        sum     = {1'b0, a} - {1'b0, b} - {{ptls_pkg::CntW{1'b0}}, 1'b1};
        res     = sum[ptls_pkg::CntW-1:0];
        no_rise = sum[ptls_pkg::CntW];
      end
      default: begin
        sum     = '0;
        res     = '0;
        no_rise = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/ptls_table.sv =====
// ----------------------------------------------------------------------------
// ptls_table - per-topic statistics memory
// One row per topic, one port read or write per cycle, registered read data.
// Row valid bits make unwritten rows read as zero right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ptls_table #(
  parameter int TOPIC_COUNT = 8
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire ptls_pkg::tbl_req_t  req,
  input  wire ptls_pkg::entry_t    wr_data,
  output ptls_pkg::entry_t         rd_data
);

  localparam int AW = (TOPIC_COUNT > 1) ? $clog2(TOPIC_COUNT) : 1;

  ptls_pkg::entry_t       mem [TOPIC_COUNT];
  logic [TOPIC_COUNT-1:0] row_valid_r;
  ptls_pkg::entry_t       rd_data_r;

  logic [AW-1:0] addr;
  assign addr = req.addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= row_valid_r[addr] ? mem[addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (req.wr_en) begin
      row_valid_r[addr] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== src/per_topic_loss_statistics_core.sv =====
// Steps: published event read, load, add, write; received event read, load, gap,
//   add received, add dropped, write (gap then write on a sender reset); push
//   reads then reports each topic, holding while the result side stalls.
// Throughput: one item at a time; the row read-modify-write through the single
//   table port and the shared adder sets the pace. in_stall is high while busy.
// Reset: synchronous, active low; row valid bits clear at once, no sweep.
// ----------------------------------------------------------------------------
// per_topic_loss_statistics_core - per-topic message loss counters
// Keeps published, received, dropped and last sequence number per topic and
// reports every topic on a push command.
// ----------------------------------------------------------------------------
`default_nettype none

module per_topic_loss_statistics_core #(
  parameter int TOPIC_COUNT = 8
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // input channel
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire logic [ptls_pkg::CmdW-1:0]    in_cmd,
  input  wire logic [ptls_pkg::TopicW-1:0]  in_topic,
  input  wire logic [ptls_pkg::SeqW-1:0]    in_seq_num,
  // result channel
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [ptls_pkg::TopicW-1:0]       out_topic_out,
  output logic [ptls_pkg::CntW-1:0]         out_published_count,
  output logic [ptls_pkg::CntW-1:0]         out_received_count,
  output logic [ptls_pkg::CntW-1:0]         out_dropped_count,
  output logic                              out_last
);

  localparam int AW = (TOPIC_COUNT > 1) ? $clog2(TOPIC_COUNT) : 1;

  // Sequencer state and latched beat
  ptls_pkg::state_t                state_r, state_nxt;
  logic [ptls_pkg::CmdW-1:0]       cmd_r, cmd_nxt;
  logic [ptls_pkg::TopicW-1:0]     topic_r, topic_nxt;
  logic [ptls_pkg::SeqW-1:0]       seq_r, seq_nxt;

  // Working copy of the row under update
  ptls_pkg::entry_t                work_r, work_nxt;
  logic [ptls_pkg::CntW-1:0]       gap_r, gap_nxt;

  // Push walk index
  logic [AW-1:0]                   k_r, k_nxt;
  logic                            k_last;

  // Output register
  logic                            out_valid_r, out_valid_nxt;
  logic [ptls_pkg::TopicW-1:0]     out_topic_r, out_topic_nxt;
  logic [ptls_pkg::CntW-1:0]       out_pub_r, out_pub_nxt;
  logic [ptls_pkg::CntW-1:0]       out_rcv_r, out_rcv_nxt;
  logic [ptls_pkg::CntW-1:0]       out_drp_r, out_drp_nxt;
  logic                            out_last_r, out_last_nxt;

  // Table and shared unit hookup
  ptls_pkg::tbl_req_t              tbl_req;
  ptls_pkg::entry_t                tbl_rd_data;
  ptls_pkg::alu_op_t               alu_op;
  logic [ptls_pkg::CntW-1:0]       alu_a, alu_b, alu_res;
  logic                            alu_no_rise;

  logic                            in_fire;
  logic                            topic_ok;
  logic                            out_free;

  ptls_table #(
    .TOPIC_COUNT (TOPIC_COUNT)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (tbl_req),
    .wr_data (work_r),
    .rd_data (tbl_rd_data)
  );

  ptls_alu u_alu (
    .op      (alu_op),
    .a       (alu_a),
    .b       (alu_b),
    .res     (alu_res),
    .no_rise (alu_no_rise)
  );

  // Take a beat only when idle
  assign in_stall = (state_r != ptls_pkg::S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign topic_ok = ({1'b0, in_topic} < (ptls_pkg::TopicW + 1)'(TOPIC_COUNT));
  // Output register can take a new result when empty or draining this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign k_last   = (k_r == AW'(TOPIC_COUNT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptls_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    topic_r     <= topic_nxt;
    seq_r       <= seq_nxt;
    work_r      <= work_nxt;
    gap_r       <= gap_nxt;
    out_topic_r <= out_topic_nxt;
    out_pub_r   <= out_pub_nxt;
    out_rcv_r   <= out_rcv_nxt;
    out_drp_r   <= out_drp_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    topic_nxt     = topic_r;
    seq_nxt       = seq_r;
    work_nxt      = work_r;
    gap_nxt       = gap_r;
    k_nxt         = k_r;
    out_topic_nxt = out_topic_r;
    out_pub_nxt   = out_pub_r;
    out_rcv_nxt   = out_rcv_r;
    out_drp_nxt   = out_drp_r;
    out_last_nxt  = out_last_r;
    // drop the held result once the far side takes it
    out_valid_nxt = out_valid_r && out_stall;

    tbl_req       = '0;
    alu_op        = ptls_pkg::ALU_ADD_SAT;
    alu_a         = '0;
    alu_b         = '0;

    case (state_r)
      ptls_pkg::S_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = in_cmd;
          topic_nxt = in_topic;
          seq_nxt   = in_seq_num;
          if (in_cmd == ptls_pkg::CMD_PUSH) begin
            k_nxt     = '0;
            state_nxt = ptls_pkg::S_PUSH_RD;
          end else if ((in_cmd == ptls_pkg::CMD_PUB || in_cmd == ptls_pkg::CMD_RCV)
                       && topic_ok) begin
            state_nxt = ptls_pkg::S_READ;
          end
          // unused command or topic out of range: drop the beat
        end
      end

      ptls_pkg::S_READ: begin
        tbl_req.rd_en = 1'b1;
        tbl_req.addr  = topic_r;
        state_nxt     = ptls_pkg::S_LOAD;
      end

      ptls_pkg::S_LOAD: begin
        work_nxt  = tbl_rd_data;
        state_nxt = (cmd_r == ptls_pkg::CMD_PUB) ? ptls_pkg::S_PUB : ptls_pkg::S_GAP;
      end

      ptls_pkg::S_PUB: begin
        alu_op       = ptls_pkg::ALU_ADD_SAT;
        alu_a        = work_r.pub;
        alu_b        = ptls_pkg::CntW'(1);
        work_nxt.pub = alu_res;
        state_nxt    = ptls_pkg::S_WRITE;
      end

      ptls_pkg::S_GAP: begin
        // compare against last sequence and form the gap in one pass
        alu_op        = ptls_pkg::ALU_GAP;
        alu_a         = {1'b0, seq_r};
        alu_b         = {1'b0, work_r.lseq};
        work_nxt.lseq = seq_r;
        if (alu_no_rise) begin
          // sender restarted its numbering
          work_nxt.pub = '0;
          work_nxt.rcv = ptls_pkg::CntW'(1);
          work_nxt.drp = '0;
          state_nxt    = ptls_pkg::S_WRITE;
        end else begin
          gap_nxt   = alu_res;
          state_nxt = ptls_pkg::S_RCV;
        end
      end

      ptls_pkg::S_RCV: begin
        alu_op       = ptls_pkg::ALU_ADD_SAT;
        alu_a        = work_r.rcv;
        alu_b        = ptls_pkg::CntW'(1);
        work_nxt.rcv = alu_res;
        state_nxt    = ptls_pkg::S_DROP;
      end

      ptls_pkg::S_DROP: begin
        alu_op       = ptls_pkg::ALU_ADD_SAT;
        alu_a        = work_r.drp;
        alu_b        = gap_r;
        work_nxt.drp = alu_res;
        state_nxt    = ptls_pkg::S_WRITE;
      end

      ptls_pkg::S_WRITE: begin
        tbl_req.wr_en = 1'b1;
        tbl_req.addr  = topic_r;
        state_nxt     = ptls_pkg::S_IDLE;
      end

      ptls_pkg::S_PUSH_RD: begin
        tbl_req.rd_en = 1'b1;
        tbl_req.addr  = ptls_pkg::TopicW'(k_r);
        state_nxt     = ptls_pkg::S_PUSH_OUT;
      end

      ptls_pkg::S_PUSH_OUT: begin
        // hold the row until the output register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_topic_nxt = ptls_pkg::TopicW'(k_r);
          out_pub_nxt   = tbl_rd_data.pub;
          out_rcv_nxt   = tbl_rd_data.rcv;
          out_drp_nxt   = tbl_rd_data.drp;
          out_last_nxt  = k_last;
          if (k_last) begin
            state_nxt = ptls_pkg::S_IDLE;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = ptls_pkg::S_PUSH_RD;
          end
        end
      end

      default: begin
        state_nxt = ptls_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_topic_out       = out_topic_r;
  assign out_published_count = out_pub_r;
  assign out_received_count  = out_rcv_r;
  assign out_dropped_count   = out_drp_r;
  assign out_last            = out_last_r;

endmodule

`default_nettype wire

// ===== tb/tb_per_topic_loss_statistics_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_topic_loss_statistics_core - self-checking bench for the loss counters
// Drives published, received, push and unused commands through the valid/stall
// input channel. A scoreboard keeps its own copy of the per-topic counters,
// predicts every push report and checks each report beat field by field.
// ----------------------------------------------------------------------------

module tb_per_topic_loss_statistics_core;

  localparam int TOPICS       = 8;
  localparam int RANDOM_ITEMS = 240;
  localparam int CALM_ITEMS   = 40;     // final stretch with no idling on either side
  localparam int IDLE_LIMIT   = 1000;   // cycles with no beat on either channel
  localparam int DRAIN_CYCLES = 2 * TOPICS + 8;
  localparam logic [ptls_pkg::SeqW-1:0] SEQ_MAX = '1;

  typedef struct {
    logic [ptls_pkg::TopicW-1:0] topic;
    logic [ptls_pkg::CntW-1:0]   published;
    logic [ptls_pkg::CntW-1:0]   received;
    logic [ptls_pkg::CntW-1:0]   dropped;
    logic                        last;
  } topic_report_t;

  // Shadow copy of the per-topic counters plus the queue of push reports
  // still owed by the block.
  class loss_stats_board;
    logic [ptls_pkg::CntW-1:0] published [TOPICS];
    logic [ptls_pkg::CntW-1:0] received  [TOPICS];
    logic [ptls_pkg::CntW-1:0] dropped   [TOPICS];
    logic [ptls_pkg::SeqW-1:0] last_seq  [TOPICS];
    topic_report_t             pending_reports[$];
    int                        failures;

    function new();
      for (int k = 0; k < TOPICS; k++) begin
        published[k] = '0;
        received[k]  = '0;
        dropped[k]   = '0;
        last_seq[k]  = '0;
      end
      failures = 0;
    endfunction

    function logic [ptls_pkg::CntW-1:0] clamp_add(logic [ptls_pkg::CntW-1:0] a,
                                                   logic [ptls_pkg::CntW-1:0] b);
      logic [ptls_pkg::CntW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[ptls_pkg::CntW] ? '1 : sum[ptls_pkg::CntW-1:0];
    endfunction

    // Update the shadow counters for one accepted beat; a push queues one
    // report per topic.
    function void apply_event(ptls_pkg::cmd_t cmd, logic [ptls_pkg::TopicW-1:0] topic,
                              logic [ptls_pkg::SeqW-1:0] seq);
      topic_report_t             rep;
      logic [ptls_pkg::CntW-1:0] gap;
      case (cmd)
        ptls_pkg::CMD_PUSH: begin
          for (int k = 0; k < TOPICS; k++) begin
            rep.topic     = ptls_pkg::TopicW'(k);
            rep.published = published[k];
            rep.received  = received[k];
            rep.dropped   = dropped[k];
            rep.last      = (k == TOPICS - 1);
            pending_reports.push_back(rep);
          end
        end
        ptls_pkg::CMD_PUB: begin
          if (topic < TOPICS)
            published[topic] = clamp_add(published[topic], ptls_pkg::CntW'(1));
        end
        ptls_pkg::CMD_RCV: begin
          if (topic < TOPICS) begin
            if (seq <= last_seq[topic]) begin
              published[topic] = '0;
              received[topic]  = ptls_pkg::CntW'(1);
              dropped[topic]   = '0;
            end else begin
              gap = {1'b0, seq} - {1'b0, last_seq[topic]} - ptls_pkg::CntW'(1);
              received[topic] = clamp_add(received[topic], ptls_pkg::CntW'(1));
              dropped[topic]  = clamp_add(dropped[topic], gap);
            end
            last_seq[topic] = seq;
          end
        end
        default: ;
      endcase
    endfunction

    function void compare(string field, logic [ptls_pkg::CntW-1:0] want,
                          logic [ptls_pkg::CntW-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_report(logic [ptls_pkg::TopicW-1:0] topic,
                               logic [ptls_pkg::CntW-1:0] pub,
                               logic [ptls_pkg::CntW-1:0] rcv,
                               logic [ptls_pkg::CntW-1:0] drp, logic last);
      topic_report_t want;
      if (pending_reports.size() == 0) begin
        $error("unexpected report beat for topic %0d", topic);
        failures++;
        return;
      end
      want = pending_reports.pop_front();
      compare("topic_out", ptls_pkg::CntW'(want.topic), ptls_pkg::CntW'(topic));
      compare("published_count", want.published, pub);
      compare("received_count", want.received, rcv);
      compare("dropped_count", want.dropped, drp);
      compare("last", ptls_pkg::CntW'(want.last), ptls_pkg::CntW'(last));
    endfunction
  endclass

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_valid   = 1'b0;
  logic                          in_stall;
  logic [ptls_pkg::CmdW-1:0]     in_cmd     = ptls_pkg::CMD_NOP;
  logic [ptls_pkg::TopicW-1:0]   in_topic   = '0;
  logic [ptls_pkg::SeqW-1:0]     in_seq_num = '0;
  logic                          out_valid;
  logic                          out_stall  = 1'b0;
  logic [ptls_pkg::TopicW-1:0]   out_topic_out;
  logic [ptls_pkg::CntW-1:0]     out_published_count;
  logic [ptls_pkg::CntW-1:0]     out_received_count;
  logic [ptls_pkg::CntW-1:0]     out_dropped_count;
  logic                          out_last;

  loss_stats_board board = new();
  bit              calm  = 1'b0;  // set for the final stretch: no idling at all

  per_topic_loss_statistics_core #(
    .TOPIC_COUNT(TOPICS)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_topic            (in_topic),
    .in_seq_num          (in_seq_num),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_topic_out       (out_topic_out),
    .out_published_count (out_published_count),
    .out_received_count  (out_received_count),
    .out_dropped_count   (out_dropped_count),
    .out_last            (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Present one beat and hold it until the block takes it. Sometimes drop
  // valid for a short burst first so gaps land on every phase of the block.
  task automatic send_event(ptls_pkg::cmd_t cmd, logic [ptls_pkg::TopicW-1:0] topic,
                            logic [ptls_pkg::SeqW-1:0] seq);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_topic   <= topic;
    in_seq_num <= seq;
    do @(posedge clk); while (in_stall);
    board.apply_event(cmd, topic, seq);
  endtask

  // Mostly well-formed traffic: in-range topics and received sequence numbers
  // that climb by small steps. Mix in sender resets, wild sequence numbers,
  // out-of-range topics, unused commands and the occasional push.
  task automatic send_random_event();
    int unsigned                 roll;
    int unsigned                 kind;
    ptls_pkg::cmd_t              cmd;
    logic [ptls_pkg::TopicW-1:0] topic;
    logic [ptls_pkg::SeqW-1:0]   prev;
    logic [ptls_pkg::SeqW-1:0]   seq;
    roll = $urandom_range(0, 99);
    if (roll < 4)       cmd = ptls_pkg::CMD_PUSH;
    else if (roll < 9)  cmd = ptls_pkg::CMD_NOP;
    else if (roll < 40) cmd = ptls_pkg::CMD_PUB;
    else                cmd = ptls_pkg::CMD_RCV;
    if ($urandom_range(0, 9) == 0) topic = ptls_pkg::TopicW'($urandom_range(TOPICS, 63));
    else                           topic = ptls_pkg::TopicW'($urandom_range(0, TOPICS - 1));
    seq = ptls_pkg::SeqW'($urandom);
    if (cmd == ptls_pkg::CMD_RCV) begin
      prev = (topic < TOPICS) ? board.last_seq[topic] : '0;
      kind = $urandom_range(0, 9);
      if (kind == 0)               seq = ptls_pkg::SeqW'($urandom);
      else if (kind == 1)          seq = ptls_pkg::SeqW'($urandom_range(0, prev));
      else if (prev > SEQ_MAX - 5) seq = ptls_pkg::SeqW'($urandom_range(0, 1000));
      else                         seq = prev + ptls_pkg::SeqW'($urandom_range(1, 5));
    end
    send_event(cmd, topic, seq);
  endtask

  // Stall the report channel in random bursts, except in the final stretch.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && !calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Check every report beat the block hands over.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_report(out_topic_out, out_published_count, out_received_count,
                         out_dropped_count, out_last);
  end

  // End the run when neither channel moves a beat for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Push straight after reset: all counters zero, and its fields are ignored.
    send_event(ptls_pkg::CMD_PUSH, 6'd63, SEQ_MAX);
    // First received beat with sequence 0 counts as a sender reset.
    send_event(ptls_pkg::CMD_RCV, 6'd0, '0);
    send_event(ptls_pkg::CMD_PUB, 6'd0, SEQ_MAX);
    send_event(ptls_pkg::CMD_PUB, ptls_pkg::TopicW'(TOPICS - 1), '0);
    // Out-of-range topics and the unused command leave everything alone.
    send_event(ptls_pkg::CMD_PUB, ptls_pkg::TopicW'(TOPICS), '0);
    send_event(ptls_pkg::CMD_RCV, 6'd63, 31'd5);
    send_event(ptls_pkg::CMD_NOP, 6'd3, 31'h2AAA_AAAA);
    // Rising without a gap, with a gap, then equal and falling (sender resets).
    send_event(ptls_pkg::CMD_RCV, 6'd1, 31'd1);
    send_event(ptls_pkg::CMD_PUB, 6'd1, '0);
    send_event(ptls_pkg::CMD_RCV, 6'd1, 31'd10);
    send_event(ptls_pkg::CMD_PUSH, 6'd0, '0);
    send_event(ptls_pkg::CMD_RCV, 6'd1, 31'd10);
    send_event(ptls_pkg::CMD_RCV, 6'd1, 31'd3);
    // Largest sequence number: widest gap, then a repeat resets the topic.
    send_event(ptls_pkg::CMD_RCV, 6'd2, SEQ_MAX);
    send_event(ptls_pkg::CMD_PUSH, 6'd21, 31'h5555_5555);
    send_event(ptls_pkg::CMD_RCV, 6'd2, SEQ_MAX);
    send_event(ptls_pkg::CMD_RCV, ptls_pkg::TopicW'(TOPICS - 1), SEQ_MAX - 1);
    send_event(ptls_pkg::CMD_PUB, ptls_pkg::TopicW'(TOPICS - 1), SEQ_MAX);
    send_event(ptls_pkg::CMD_NOP, 6'd63, SEQ_MAX);
    send_event(ptls_pkg::CMD_PUSH, 6'd42, 31'h1234_5678);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      send_random_event();
    end
    // Close with a push so the final counters are read back.
    send_event(ptls_pkg::CMD_PUSH, '0, '0);
    in_valid <= 1'b0;

    while (board.pending_reports.size() != 0) @(posedge clk);
    // Catch any stray report beat after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
